>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, compiled out when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// antecedent implies consequent in the same cycle
`define QKT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("qkt assertion failed");
// antecedent implies consequent in the next cycle
`define QKT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("qkt assertion failed");
`else
`define QKT_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define QKT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> hw/rtl/qkt_pkg.sv
// ----------------------------------------------------------------------------
// qkt_pkg
// types, token kinds, character codes and keyword table of the tokenizer
// ----------------------------------------------------------------------------
`default_nettype none

package qkt_pkg;

    localparam int KW_COUNT   = 37;
    localparam int KW_MAX_LEN = 15;

    // item on the input channel
    typedef struct packed {
        logic [7:0] ch;
        logic       has_char;
        logic       last;
    } t_in_item;

    // item on the output channel
    typedef struct packed {
        logic [5:0]  token_kind;
        logic [15:0] start_pos;
        logic [15:0] text_length;
        logic        run_last;
    } t_out_item;

    // one token produced by the scanner
    typedef struct packed {
        logic [5:0]  kind;
        logic [15:0] start;
        logic [15:0] length;
    } t_token;

    // all tokens caused by one item
    typedef struct packed {
        logic [1:0]       count;
        t_token [2:0]     tok;
    } t_step_res;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_STRING,
        MODE_NUMBER,
        MODE_IDENT,
        MODE_BANG,
        MODE_LESS
    } t_mode;

    typedef logic [8*KW_MAX_LEN-1:0] t_kw_text;

    // token kinds
    localparam logic [5:0] KIND_END      = 6'd0;
    localparam logic [5:0] KIND_COMMA    = 6'd1;
    localparam logic [5:0] KIND_DOT      = 6'd2;
    localparam logic [5:0] KIND_LPAREN   = 6'd3;
    localparam logic [5:0] KIND_RPAREN   = 6'd4;
    localparam logic [5:0] KIND_SEMI     = 6'd5;
    localparam logic [5:0] KIND_STAR     = 6'd6;
    localparam logic [5:0] KIND_EQUAL    = 6'd7;
    localparam logic [5:0] KIND_NOTEQUAL = 6'd8;
    localparam logic [5:0] KIND_REGEX    = 6'd9;
    localparam logic [5:0] KIND_STRING   = 6'd10;
    localparam logic [5:0] KIND_NUMBER   = 6'd11;
    localparam logic [5:0] KIND_IDENT    = 6'd12;
    localparam logic [5:0] KIND_KW0      = 6'd13;

    // character codes
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_BANG    = 8'h21;
    localparam logic [7:0] CH_DQUOTE  = 8'h22;
    localparam logic [7:0] CH_SQUOTE  = 8'h27;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_HYPHEN  = 8'h2D;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_DIGIT0  = 8'h30;
    localparam logic [7:0] CH_DIGIT9  = 8'h39;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_LESS    = 8'h3C;
    localparam logic [7:0] CH_EQUAL   = 8'h3D;
    localparam logic [7:0] CH_GREATER = 8'h3E;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_UNDER   = 8'h5F;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_TILDE   = 8'h7E;
    localparam logic [7:0] CASE_DIFF  = 8'h20;

    localparam logic [KW_COUNT-1:0] CAND_ALL = '1;

    // keyword text, right aligned, first character in the highest used byte
    localparam t_kw_text KW_TEXT [KW_COUNT] = '{
        "SELECT", "FROM", "WHERE", "AND", "OR", "IN", "EXISTS", "DOCUMENT",
        "LIMIT", "EXCLUDE", "ORDER", "BY", "ASC", "DESC", "AS", "TO", "LIST",
        "COUNT", "TABLE", "CSV", "PARQUET", "RAW", "FRAGMENTS", "CONTAINS",
        {"HAS_DIRECT", "_TEXT"}, "ALL", "ANY", "IS", "NOT", "NULL", "SHOW",
        "DESCRIBE", "INPUT", "INPUTS", "FUNCTIONS", "AXES", "OPERATORS"
    };

    localparam logic [3:0] KW_LEN [KW_COUNT] = '{
        4'd6, 4'd4, 4'd5, 4'd3, 4'd2, 4'd2, 4'd6, 4'd8,
        4'd5, 4'd7, 4'd5, 4'd2, 4'd3, 4'd4, 4'd2, 4'd2, 4'd4,
        4'd5, 4'd5, 4'd3, 4'd7, 4'd3, 4'd9, 4'd8,
        4'd15, 4'd3, 4'd3, 4'd2, 4'd3, 4'd4, 4'd4,
        4'd8, 4'd5, 4'd6, 4'd9, 4'd4, 4'd9
    };

    // drop candidates whose character at idx differs, case folded
    function automatic logic [KW_COUNT-1:0] kw_narrow(
        input logic [KW_COUNT-1:0] cand,
        input logic [7:0]          ch,
        input logic [4:0]          idx
    );
        logic [KW_COUNT-1:0] res;
        logic [7:0]          up;
        logic [3:0]          pos;
        logic [7:0]          kb;
        logic                in_len;
        res = cand;
        up  = (ch >= CH_LOWER_A && ch <= CH_LOWER_Z) ? ch - CASE_DIFF : ch;
        for (int k = 0; k < KW_COUNT; k++) begin
            pos    = 4'd0;
            kb     = 8'h00;
            in_len = (idx < {1'b0, KW_LEN[k]});
            if (in_len) begin
                pos = KW_LEN[k] - 4'd1 - idx[3:0];
                kb  = KW_TEXT[k][{pos, 3'b000} +: 8];
            end
            if (!in_len || kb != up) begin
                res[k] = 1'b0;
            end
        end
        return res;
    endfunction

    // kind of an identifier: the surviving keyword of matching length
    function automatic logic [5:0] kw_classify(
        input logic [KW_COUNT-1:0] cand,
        input logic [4:0]          len
    );
        logic [5:0] kind;
        kind = KIND_IDENT;
        for (int k = KW_COUNT - 1; k >= 0; k--) begin
            if (cand[k] && len == {1'b0, KW_LEN[k]}) begin
                kind = KIND_KW0 + 6'(k);
            end
        end
        return kind;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/qkt_scan.sv
// ----------------------------------------------------------------------------
// qkt_scan
// scanner state and the combinational step that turns one item into tokens
// ----------------------------------------------------------------------------
`default_nettype none

module qkt_scan import qkt_pkg::*; #(
    parameter int POS_BITS = 16
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    input  wire t_in_item  i_item,
    output t_step_res      o_res
);

    localparam logic [POS_BITS-1:0] POS_MAX = '1;

    t_mode                 r_mode,  n_mode;
    logic                  r_dq,    n_dq;
    logic [POS_BITS-1:0]   r_cpos,  n_cpos;
    logic [POS_BITS-1:0]   r_tbeg,  n_tbeg;
    logic [POS_BITS-1:0]   r_rlen,  n_rlen;
    logic [KW_COUNT-1:0]   r_cand,  n_cand;

    logic [KW_COUNT-1:0]   nar_cand;
    logic                  go_idle;
    logic [7:0]            ch;
    logic [5:0]            punct;
    t_token                ev [4];
    logic [3:0]            ev_vld;
    logic [1:0]            cnt;

    function automatic logic [POS_BITS-1:0] sat_inc(input logic [POS_BITS-1:0] v);
        return (v == POS_MAX) ? v : v + 1'b1;
    endfunction

    // keyword index, clamped past the longest keyword
    function automatic logic [4:0] kw_index(input logic [POS_BITS-1:0] v);
        return (|v[POS_BITS-1:4]) ? 5'd16 : {1'b0, v[3:0]};
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= CH_DIGIT0 && c <= CH_DIGIT9;
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= CH_UPPER_A && c <= CH_UPPER_Z) || (c >= CH_LOWER_A && c <= CH_LOWER_Z);
    endfunction

    function automatic logic is_ident_cont(input logic [7:0] c);
        return is_alpha(c) || is_digit(c) || c == CH_UNDER || c == CH_HYPHEN;
    endfunction

    function automatic t_token mk_tok(
        input logic [5:0]          kind,
        input logic [POS_BITS-1:0] start,
        input logic [POS_BITS-1:0] len
    );
        t_token t;
        t.kind   = kind;
        t.start  = 16'(start);
        t.length = 16'(len);
        return t;
    endfunction

    assign ch = i_item.ch;

    // one narrowing unit: continue an identifier or start a fresh one
    assign nar_cand = kw_narrow((r_mode == MODE_IDENT) ? r_cand : CAND_ALL, ch,
                                (r_mode == MODE_IDENT) ? kw_index(r_rlen) : 5'd0);

    // single punctuation marks
    always_comb begin
        case (ch)
            CH_COMMA:  punct = KIND_COMMA;
            CH_DOT:    punct = KIND_DOT;
            CH_LPAREN: punct = KIND_LPAREN;
            CH_RPAREN: punct = KIND_RPAREN;
            CH_SEMI:   punct = KIND_SEMI;
            CH_STAR:   punct = KIND_STAR;
            CH_EQUAL:  punct = KIND_EQUAL;
            CH_TILDE:  punct = KIND_REGEX;
            default:   punct = KIND_END;
        endcase
    end

    // next state and the tokens of this item, in emission order
    always_comb begin
        n_mode  = r_mode;
        n_dq    = r_dq;
        n_cpos  = r_cpos;
        n_tbeg  = r_tbeg;
        n_rlen  = r_rlen;
        n_cand  = r_cand;
        go_idle = 1'b0;
        ev_vld  = 4'b0000;
        for (int i = 0; i < 4; i++) begin
            ev[i] = mk_tok(KIND_END, '0, '0);
        end

        if (i_item.has_char) begin
            // close or extend the open token
            case (r_mode)
                MODE_STRING: begin
                    if (ch == (r_dq ? CH_DQUOTE : CH_SQUOTE)) begin
                        ev_vld[0] = 1'b1;
                        ev[0]     = mk_tok(KIND_STRING, r_tbeg, r_rlen);
                        n_mode    = MODE_IDLE;
                    end else begin
                        n_rlen = sat_inc(r_rlen);
                    end
                end
                MODE_NUMBER: begin
                    if (is_digit(ch)) begin
                        n_rlen = sat_inc(r_rlen);
                    end else begin
                        ev_vld[0] = 1'b1;
                        ev[0]     = mk_tok(KIND_NUMBER, r_tbeg, r_rlen);
                        go_idle   = 1'b1;
                    end
                end
                MODE_IDENT: begin
                    if (is_ident_cont(ch)) begin
                        n_cand = nar_cand;
                        n_rlen = sat_inc(r_rlen);
                    end else begin
                        ev_vld[0] = 1'b1;
                        ev[0]     = mk_tok(kw_classify(r_cand, kw_index(r_rlen)),
                                           r_tbeg, r_rlen);
                        go_idle   = 1'b1;
                    end
                end
                MODE_BANG, MODE_LESS: begin
                    ev_vld[0] = 1'b1;
                    if (ch == ((r_mode == MODE_BANG) ? CH_EQUAL : CH_GREATER)) begin
                        ev[0]  = mk_tok(KIND_NOTEQUAL, r_tbeg, POS_BITS'(2));
                        n_mode = MODE_IDLE;
                    end else begin
                        ev[0]   = mk_tok(KIND_END, r_tbeg, '0);
                        go_idle = 1'b1;
                    end
                end
                default: begin
                    go_idle = 1'b1;
                end
            endcase

            // scan the character afresh from idle
            if (go_idle) begin
                n_mode = MODE_IDLE;
                if (is_space(ch)) begin
                    n_mode = MODE_IDLE;
                end else if (punct != KIND_END) begin
                    ev_vld[1] = 1'b1;
                    ev[1]     = mk_tok(punct, r_cpos, POS_BITS'(1));
                end else if (ch == CH_BANG || ch == CH_LESS) begin
                    n_mode = (ch == CH_BANG) ? MODE_BANG : MODE_LESS;
                    n_tbeg = r_cpos;
                end else if (ch == CH_SQUOTE || ch == CH_DQUOTE) begin
                    n_mode = MODE_STRING;
                    n_dq   = (ch == CH_DQUOTE);
                    n_tbeg = r_cpos;
                    n_rlen = '0;
                end else if (is_digit(ch)) begin
                    n_mode = MODE_NUMBER;
                    n_tbeg = r_cpos;
                    n_rlen = POS_BITS'(1);
                end else if (is_alpha(ch) || ch == CH_UNDER) begin
                    n_mode = MODE_IDENT;
                    n_tbeg = r_cpos;
                    n_cand = nar_cand;
                    n_rlen = POS_BITS'(1);
                end else begin
                    ev_vld[1] = 1'b1;
                    ev[1]     = mk_tok(KIND_END, r_cpos, '0);
                end
            end
            n_cpos = sat_inc(r_cpos);
        end

        // end of query: flush the open token, end token, back to reset state
        if (i_item.last) begin
            case (n_mode)
                MODE_STRING: begin
                    ev_vld[2] = 1'b1;
                    ev[2]     = mk_tok(KIND_STRING, n_tbeg, n_rlen);
                end
                MODE_NUMBER: begin
                    ev_vld[2] = 1'b1;
                    ev[2]     = mk_tok(KIND_NUMBER, n_tbeg, n_rlen);
                end
                MODE_IDENT: begin
                    ev_vld[2] = 1'b1;
                    ev[2]     = mk_tok(kw_classify(n_cand, kw_index(n_rlen)), n_tbeg, n_rlen);
                end
                MODE_BANG, MODE_LESS: begin
                    ev_vld[2] = 1'b1;
                    ev[2]     = mk_tok(KIND_END, n_tbeg, '0);
                end
                default: begin
                    ev_vld[2] = 1'b0;
                end
            endcase
            ev_vld[3] = 1'b1;
            ev[3]     = mk_tok(KIND_END, n_cpos, '0);
            n_mode    = MODE_IDLE;
            n_dq      = 1'b0;
            n_cpos    = '0;
            n_tbeg    = '0;
            n_rlen    = '0;
            n_cand    = CAND_ALL;
        end
    end

    // pack valid tokens into the result slots, at most three kept
    always_comb begin
        cnt   = 2'd0;
        o_res = '0;
        for (int i = 0; i < 4; i++) begin
            if (ev_vld[i] && cnt != 2'd3) begin
                o_res.tok[cnt] = ev[i];
                cnt            = cnt + 2'd1;
            end
        end
        o_res.count = cnt;
    end

    // scanner state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
            r_dq   <= 1'b0;
            r_cpos <= '0;
            r_tbeg <= '0;
            r_rlen <= '0;
            r_cand <= CAND_ALL;
        end else if (i_valid) begin
            r_mode <= n_mode;
            r_dq   <= n_dq;
            r_cpos <= n_cpos;
            r_tbeg <= n_tbeg;
            r_rlen <= n_rlen;
            r_cand <= n_cand;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/qkt_res_buf.sv
// ----------------------------------------------------------------------------
// qkt_res_buf
// result register holding the tokens of one item, sent out one per handshake
// ----------------------------------------------------------------------------
`default_nettype none

module qkt_res_buf import qkt_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_load,
    input  wire t_step_res i_res,
    input  wire logic      i_out_stall,
    output logic           o_free,
    output logic           o_out_valid,
    output t_out_item      o_out_data
);

    t_token     r_tok [3];
    logic [1:0] r_rem;
    logic [1:0] r_idx;
    logic       pop;
    t_token     cur;

    assign pop         = (r_rem != 2'd0) && !i_out_stall;
    assign o_free      = (r_rem == 2'd0) || (r_rem == 2'd1 && pop);
    assign o_out_valid = (r_rem != 2'd0);

    // present the next token, last one of the item flagged
    assign cur                    = r_tok[r_idx];
    assign o_out_data.token_kind  = cur.kind;
    assign o_out_data.start_pos   = cur.start;
    assign o_out_data.text_length = cur.length;
    assign o_out_data.run_last    = (r_rem == 2'd1);

    // slot count and read index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem <= 2'd0;
            r_idx <= 2'd0;
        end else if (i_load && i_res.count != 2'd0) begin
            r_rem <= i_res.count;
            r_idx <= 2'd0;
        end else if (pop) begin
            r_rem <= r_rem - 2'd1;
            r_idx <= r_idx + 2'd1;
        end
    end

    // token slots
    always_ff @(posedge i_clk) begin
        if (i_load && i_res.count != 2'd0) begin
            for (int i = 0; i < 3; i++) begin
                r_tok[i] <= i_res.tok[i];
            end
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/query_keyword_tokenizer.sv
// ----------------------------------------------------------------------------
// query_keyword_tokenizer: streaming query tokenizer with keyword matching
// path: an accepted item enters the input register, then its results the result register
// throughput: one item per cycle, held off by i_out_stall or by multi-result items
// reset: i_rst_n synchronous active low, clears scanner state and position to 0
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module query_keyword_tokenizer import qkt_pkg::*; #(
    parameter int POS_BITS = 16
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_item  i_in_data,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_item      o_out_data
);

    logic       r_in_vld;
    t_in_item   r_in;
    logic       buf_free;
    logic       adv;
    t_step_res  step_res;

    assign adv        = r_in_vld && buf_free;
    assign o_in_stall = r_in_vld && !buf_free;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in_data;
        end
    end

    // scanner step
    qkt_scan #(
        .POS_BITS (POS_BITS)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (adv),
        .i_item  (r_in),
        .o_res   (step_res)
    );

    // result register
    qkt_res_buf u_res_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (adv),
        .i_res       (step_res),
        .i_out_stall (i_out_stall),
        .o_free      (buf_free),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    // an empty result register always takes the waiting item
    `QKT_ASSERT_SAME(a_empty_takes_item, i_clk, i_rst_n, r_in_vld && !o_out_valid, !o_in_stall)
    // the rest of an item's results follow right after a non-final result
    `QKT_ASSERT_NEXT(a_run_continues, i_clk, i_rst_n, o_out_valid && !i_out_stall && !o_out_data.run_last, o_out_valid)
    // end of query always yields at least the end token
    `QKT_ASSERT_NEXT(a_last_gives_result, i_clk, i_rst_n, adv && r_in.last, o_out_valid)

endmodule

`default_nettype wire
